// ===== rtl/core/a51kg_pkg.sv =====
// Package for the A5/1 keystream generator: constants, state codes and LFSR step functions.
package a51kg_pkg;

    // Register lengths
    localparam int unsigned ONE_W   = 19;
    localparam int unsigned TWO_W   = 22;
    localparam int unsigned THREE_W = 23;

    // Load and mixing lengths
    localparam int unsigned KEY_BITS   = 64;
    localparam int unsigned FRAME_BITS = 22;
    localparam int unsigned MIX_CLOCKS = 100;
    localparam int unsigned BYTE_BITS  = 8;

    // Step counter covers the longest phase (counts 0 to 255)
    localparam int unsigned CNT_W = 8;

    // Clocking bit positions
    localparam int unsigned ONE_CLK   = 10;
    localparam int unsigned TWO_CLK   = 11;
    localparam int unsigned THREE_CLK = 12;

    // Config port: one 64-bit register at byte address 0
    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 64;
    localparam logic        REG_SESSION_KEY = 1'b0;

    // Input mode codes (carried on tuser)
    localparam logic MODE_INIT = 1'b0;
    localparam logic MODE_BYTE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_FRAME,
        ST_MIX,
        ST_BYTE,
        ST_DONE
    } t_state;

    // One shift toward bit 0, feedback (with extra bit) entering at the top
    function automatic logic [ONE_W-1:0] step_one(input logic [ONE_W-1:0] r, input logic x);
        logic fb;
        fb = r[5] ^ r[2] ^ r[1] ^ r[0] ^ x;
        return {fb, r[ONE_W-1:1]};
    endfunction

    function automatic logic [TWO_W-1:0] step_two(input logic [TWO_W-1:0] r, input logic x);
        logic fb;
        fb = r[1] ^ r[0] ^ x;
        return {fb, r[TWO_W-1:1]};
    endfunction

    function automatic logic [THREE_W-1:0] step_three(input logic [THREE_W-1:0] r,
                                                        input logic x);
        logic fb;
        fb = r[15] ^ r[2] ^ r[1] ^ r[0] ^ x;
        return {fb, r[THREE_W-1:1]};
    endfunction

endpackage

// ===== rtl/core/a51_keystream_generator.sv =====
// A5/1 keystream generator: three LFSRs loaded bit-serially, majority clocked.
//
//  Channel   Signals                         Payload
//  s (in)    i_s_tvalid/o_s_tready           tuser = mode, tdata[21:0] = frame_number
//  m (out)   o_m_tvalid/i_m_tready           tdata[7:0] = key_byte
//  cfg       i_psel/i_penable/i_pwrite/...   session_key at address 0 (64-bit data)
//
//  Init item: 64 key steps + 22 frame steps + 100 mixing steps, then ST_DONE moves the result to
//  the output register. Byte item: 8 majority steps, then ST_DONE; one LFSR step a cycle while stepping.
//  An item is taken in ST_IDLE and holds the core until ST_DONE passes its result on.
//  Synchronous active-low reset clears the LFSRs, the key and all control state.
//  A new item is taken whenever the core is idle, even while the last result waits;
//  a finished result holds in ST_DONE until the output register is free.
module a51_keystream_generator
    import a51kg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [23:0]       i_s_tdata,   // [21:0] frame_number, [23:22] zero
    input  logic              i_s_tuser,   // [0] mode
    // output stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,   // [7:0] key_byte
    // config port
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output logic              o_pready
);

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [KEY_BITS-1:0]  r_session_key;
    logic [KEY_BITS-1:0]  r_key_sh, n_key_sh;
    logic [FRAME_BITS-1:0] r_frame_sh, n_frame_sh;
    logic [ONE_W-1:0]     r_one, n_one;
    logic [TWO_W-1:0]     r_two, n_two;
    logic [THREE_W-1:0]   r_three, n_three;
    logic [BYTE_BITS-1:0] r_byte, n_byte;
    logic                 r_out_valid, n_out_valid;
    logic [BYTE_BITS-1:0] r_out_data, n_out_data;

    logic s_xfer, out_free, maj, load_bit;
    logic [ONE_W-1:0]   one_stepped;
    logic [TWO_W-1:0]   two_stepped;
    logic [THREE_W-1:0] three_stepped;
    logic [ONE_W-1:0]   one_maj;
    logic [TWO_W-1:0]   two_maj;
    logic [THREE_W-1:0] three_maj;

    // Config register
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[3] == REG_SESSION_KEY) ? r_session_key : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session_key <= '0;
        end else if (i_psel && i_penable && i_pwrite && i_paddr[3] == REG_SESSION_KEY) begin
            r_session_key <= i_pwdata;
        end
    end

    // Handshakes
    assign o_s_tready = (r_state == ST_IDLE);
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Load bit for the all-register steps
    assign load_bit = (r_state == ST_KEY) ? r_key_sh[0] : r_frame_sh[0];

    // Plain steps with the load bit mixed into the feedback
    assign one_stepped   = step_one(r_one, load_bit);
    assign two_stepped   = step_two(r_two, load_bit);
    assign three_stepped = step_three(r_three, load_bit);

    // Majority-clocked step
    always_comb begin
        maj = (r_one[ONE_CLK] & r_two[TWO_CLK]) | (r_one[ONE_CLK] & r_three[THREE_CLK])
            | (r_two[TWO_CLK] & r_three[THREE_CLK]);
        one_maj   = (r_one[ONE_CLK] == maj)     ? step_one(r_one, 1'b0)       : r_one;
        two_maj   = (r_two[TWO_CLK] == maj)     ? step_two(r_two, 1'b0)       : r_two;
        three_maj = (r_three[THREE_CLK] == maj) ? step_three(r_three, 1'b0)   : r_three;
    end

    // State, counter, output-valid and LFSR registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_one       <= '0;
            r_two       <= '0;
            r_three     <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_one       <= n_one;
            r_two       <= n_two;
            r_three     <= n_three;
        end
    end

    // Payload shift registers and output data
    always_ff @(posedge i_clk) begin
        r_key_sh   <= n_key_sh;
        r_frame_sh <= n_frame_sh;
        r_byte     <= n_byte;
        r_out_data <= n_out_data;
    end

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_key_sh    = r_key_sh;
        n_frame_sh  = r_frame_sh;
        n_byte      = r_byte;
        n_one       = r_one;
        n_two       = r_two;
        n_three     = r_three;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // output register drains independently
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    n_cnt = '0;
                    if (i_s_tuser == MODE_INIT) begin
                        n_one      = '0;
                        n_two      = '0;
                        n_three    = '0;
                        n_key_sh   = r_session_key;
                        n_frame_sh = i_s_tdata[FRAME_BITS-1:0];
                        n_state    = ST_KEY;
                    end else begin
                        n_state = ST_BYTE;
                    end
                end
            end
            ST_KEY: begin
                n_one    = one_stepped;
                n_two    = two_stepped;
                n_three  = three_stepped;
                n_key_sh = {1'b0, r_key_sh[KEY_BITS-1:1]};
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(KEY_BITS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_FRAME;
                end
            end
            ST_FRAME: begin
                n_one      = one_stepped;
                n_two      = two_stepped;
                n_three    = three_stepped;
                n_frame_sh = {1'b0, r_frame_sh[FRAME_BITS-1:1]};
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FRAME_BITS - 1)) begin
                    n_cnt   = '0;
                    n_byte  = '0;
                    n_state = (MIX_CLOCKS == 0) ? ST_DONE : ST_MIX;
                end
            end
            ST_MIX: begin
                n_one   = one_maj;
                n_two   = two_maj;
                n_three = three_maj;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MIX_CLOCKS - 1)) begin
                    n_cnt   = '0;
                    n_byte  = '0;
                    n_state = ST_DONE;
                end
            end
            ST_BYTE: begin
                // keystream bit taken before this step's clock, first bit ends in bit 7
                n_byte  = {r_byte[BYTE_BITS-2:0], r_one[0] ^ r_two[0] ^ r_three[0]};
                n_one   = one_maj;
                n_two   = two_maj;
                n_three = three_maj;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(BYTE_BITS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_byte;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
